// File: design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque core.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 4;
  localparam int CMD_W  = 2;
  localparam int STS_W  = 2;

  // Command codes carried on in_tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  // Result status codes carried on out_tuser.
  localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming beat
    logic exec;      // update pointers, count and storage
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

endpackage

// File: design/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer of the deque: takes a beat, executes it, then hands the result
// to the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    dp_cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dp_cmd.capture = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        // The next beat may enter as the result leaves.
        if (out_free) begin
          dp_cmd.load_out = 1'b1;
          in_tready       = 1'b1;
          if (in_tvalid) begin
            dp_cmd.capture = 1'b1;
            state_nxt      = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = dp_cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: design/cdq_dp.sv
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath of the deque: ring pointers, element count, slot storage and the
// result register.
// ----------------------------------------------------------------------------
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           dp_cmd,
  input  logic [CMD_W-1:0]  cmd_in,
  input  logic [DATA_W-1:0] value_in,
  output logic [DATA_W-1:0] popped_value,
  output logic [STS_W-1:0]  status,
  output logic [OCC_W-1:0]  occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [STS_W-1:0]  res_sts_r, res_sts_nxt;
  logic              res_pop_r, res_pop_nxt;
  logic [DATA_W-1:0] popped_r;
  logic [STS_W-1:0]  status_r;
  logic [OCC_W-1:0]  occ_r;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] rdata;

  logic          is_push, is_front, full, empty;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

  assign is_push  = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_PUSH_REAR);
  assign is_front = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_POP_FRONT);
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);

  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? LAST_SLOT : tail_r - AW'(1);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    res_sts_nxt = res_sts_r;
    res_pop_nxt = res_pop_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = '0;
    raddr       = is_front ? head_r : tail_r;
    if (dp_cmd.exec) begin
      res_sts_nxt = ST_DONE;
      res_pop_nxt = 1'b0;
      if (is_push) begin
        if (full) begin
          res_sts_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
          if (empty) begin
            // First element always lands in slot zero.
            head_nxt = '0;
            tail_nxt = '0;
            waddr    = '0;
          end else if (is_front) begin
            head_nxt = head_dec;
            waddr    = head_dec;
          end else begin
            tail_nxt = tail_inc;
            waddr    = tail_inc;
          end
        end
      end else begin
        if (empty) begin
          res_sts_nxt = ST_EMPTY;
        end else begin
          re          = 1'b1;
          res_pop_nxt = 1'b1;
          count_nxt   = count_r - CW'(1);
          if (is_front) begin
            head_nxt = head_inc;
          end else begin
            tail_nxt = tail_dec;
          end
          // Removing the last element rewinds both pointers.
          if (count_r == CW'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_sts_r <= res_sts_nxt;
    res_pop_r <= res_pop_nxt;
    if (dp_cmd.capture) begin
      cmd_r <= cmd_in;
      val_r <= value_in;
    end
    if (dp_cmd.load_out) begin
      popped_r <= res_pop_r ? rdata : '0;
      status_r <= res_sts_r;
      occ_r    <= OCC_W'(count_r);
    end
  end

  cdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(val_r),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign popped_value = popped_r;
  assign status       = status_r;
  assign occupancy    = occ_r;

endmodule

// File: design/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core
// Ring double-ended queue of DEPTH signed 32-bit values.
// ----------------------------------------------------------------------------
// Each input beat carries a command on in_tuser (push front, push rear,
// pop front, pop rear) and a push value on in_tdata. Every command yields
// exactly one output beat: the popped value (zero unless a pop succeeded)
// and the occupancy after the command on out_tdata, and the status (done,
// refused because full or empty) on out_tuser. Refused commands change nothing.
// An accepted beat is first captured, then executed, which updates the
// pointers and issues the slot read, then its result is loaded from the
// registered read port of the slot RAM into the registered output. The
// core takes no new beat until the last one's result is loaded.
// A finished result sits in the output register; the next beat is taken in
// the same cycle the result is loaded, so while the receiver stalls one
// more command can be executed and hold its result behind the output
// register. in_tready then stays low until out_tready frees the register.
// Reset (rst_n low, synchronous) empties the deque and drops any pending
// result; the slot storage itself is not cleared.
// ----------------------------------------------------------------------------
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] command
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] popped_value, [35:32] occupancy, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  dp_cmd_t           dp_cmd;
  logic [DATA_W-1:0] popped_value;
  logic [OCC_W-1:0]  occupancy;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .dp_cmd    (dp_cmd)
  );

  cdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .cmd_in      (in_tuser),
    .value_in    (in_tdata),
    .popped_value(popped_value),
    .status      (out_tuser),
    .occupancy   (occupancy)
  );

  assign out_tdata = {4'b0000, occupancy, popped_value};

  // A beat just taken is still being executed, so no second beat follows
  // in the very next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted in consecutive cycles");

  // A refused pop means the deque was empty: nothing popped, nothing held.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |->
      (out_tdata[31:0] == 32'd0 && out_tdata[35:32] == 4'd0))
    else $error("empty refusal with nonzero value or occupancy");

  // A refused push means the deque was full.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |->
      (out_tdata[31:0] == 32'd0 && out_tdata[35:32] == OCC_W'(DEPTH)))
    else $error("full refusal with wrong value or occupancy");

endmodule

// File: bench/tb_circular_deque_core.sv
// ----------------------------------------------------------------------------
// tb_circular_deque_core
// Self-checking bench for the ring double-ended queue core.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty and full refusals, the
// first push into an empty deque, the pop that empties it, front pointer wrap in
// both directions and the extreme push values. About 1500 random commands follow,
// biased in phases toward pushes or pops so that the deque keeps swinging
// between empty and full. Every accepted command is run through a local
// copy of the deque, and each output beat is compared with the oldest
// expected result. Both sides insert random idle cycles, with stretches of
// back-to-back traffic in between.
// ----------------------------------------------------------------------------
module tb_circular_deque_core;
  import cdq_pkg::*;

  localparam int DEPTH    = 8;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int MAX_WAIT = 13;
  localparam int RAND_CMDS = 1500;

  // Expected content of one output beat.
  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic [STS_W-1:0]  status;
    logic [OCC_W-1:0]  occupancy;
  } deque_result_t;

  // One row of the directed table. When hand_checked is set, the row carries
  // its own expected result instead of the one the local deque computes.
  typedef struct {
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
    bit                hand_checked;
    deque_result_t     want;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  // Local copy of the deque, advanced once per accepted input beat.
  logic [DATA_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  front_ptr  = '0;
  logic [PTR_W-1:0]  rear_ptr   = '0;
  logic [OCC_W-1:0]  fill_level = '0;

  deque_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int            mismatch_count = 0;
  int            stall_left     = 0;
  bit            quiet_stretch  = 1'b0;

  always #6 clk = ~clk;

  circular_deque_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Idle cycles before the next beat on either side; zero while a
  // back-to-back stretch is running.
  function automatic int draw_wait();
    return quiet_stretch ? 0 : $urandom_range(MAX_WAIT, 0);
  endfunction

  // Apply one command to the local deque and return the beat it must yield.
  // A refused command leaves everything as it was.
  function automatic deque_result_t apply_command(cmd_t cmd, logic [DATA_W-1:0] value);
    deque_result_t res;
    res = '{popped: '0, status: ST_DONE, occupancy: '0};
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (fill_level == OCC_W'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          if (fill_level == '0) begin
            // The first element always lands in slot 0.
            front_ptr   = '0;
            rear_ptr    = '0;
            ring_mem[0] = value;
          end else if (cmd == CMD_PUSH_FRONT) begin
            front_ptr = (front_ptr == '0) ? PTR_W'(DEPTH - 1) : front_ptr - PTR_W'(1);
            ring_mem[front_ptr] = value;
          end else begin
            rear_ptr = (rear_ptr == PTR_W'(DEPTH - 1)) ? '0 : rear_ptr + PTR_W'(1);
            ring_mem[rear_ptr] = value;
          end
          fill_level = fill_level + OCC_W'(1);
        end
      end
      default: begin
        if (fill_level == '0) begin
          res.status = ST_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            res.popped = ring_mem[front_ptr];
            front_ptr  = (front_ptr == PTR_W'(DEPTH - 1)) ? '0 : front_ptr + PTR_W'(1);
          end else begin
            res.popped = ring_mem[rear_ptr];
            rear_ptr   = (rear_ptr == '0) ? PTR_W'(DEPTH - 1) : rear_ptr - PTR_W'(1);
          end
          fill_level = fill_level - OCC_W'(1);
          // Taking the last element sends both pointers home.
          if (fill_level == '0) begin
            front_ptr = '0;
            rear_ptr  = '0;
          end
        end
      end
    endcase
    res.occupancy = fill_level;
    return res;
  endfunction

  function automatic void add_row(cmd_t cmd, logic [DATA_W-1:0] value, bit hand_checked,
                                  logic [DATA_W-1:0] popped, logic [STS_W-1:0] status,
                                  logic [OCC_W-1:0] occupancy);
    stim_row_t row;
    row.cmd          = cmd;
    row.value        = value;
    row.hand_checked = hand_checked;
    row.want         = '{popped: popped, status: status, occupancy: occupancy};
    directed_rows.push_back(row);
  endfunction

  // Present one command and hold it until the core takes it. The task is
  // entered at the edge where the previous beat was taken (or right after
  // reset), so in_tvalid gets exactly one assignment in that time step.
  // With drain set, the sender first waits until every result is back.
  task automatic send_command(input cmd_t cmd, input logic [DATA_W-1:0] value,
                              input bit drain, input bit hand_checked,
                              input deque_result_t hand_want);
    int            gap;
    deque_result_t predicted;
    gap = draw_wait();
    if (drain || gap > 0) begin
      in_tvalid <= 1'b0;
      if (drain) begin
        do begin
          @(posedge clk);
        end while (pending_results.size() != 0);
      end
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do begin
      @(posedge clk);
    end while (!in_tready);
    predicted = apply_command(cmd, value);
    pending_results.push_back(hand_checked ? hand_want : predicted);
  endtask

  // Result side: compare every accepted beat with the oldest expectation,
  // then draw how long out_tready stays low before the next one.
  always @(posedge clk) begin : result_check
    deque_result_t want;
    deque_result_t got;
    int            next_stall;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{popped: out_tdata[31:0], status: out_tuser, occupancy: out_tdata[35:32]};
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result beat: popped=%h status=%0d occupancy=%0d",
                     got.popped, got.status, got.occupancy);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          // The padding bits above the occupancy must read zero as well.
          if (got !== want || out_tdata[39:36] !== 4'b0) begin
            if (mismatch_count < 10)
              $display("result mismatch: expected popped=%h status=%0d occupancy=%0d, ",
                       want.popped, want.status, want.occupancy,
                       "got popped=%h status=%0d occupancy=%0d pad=%h",
                       got.popped, got.status, got.occupancy, out_tdata[39:36]);
            mismatch_count++;
          end
        end
        next_stall = draw_wait();
        if (next_stall == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left <= next_stall;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        if (stall_left == 1) out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    deque_result_t     no_want;
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
    int                push_percent;
    int                phase_left;
    no_want      = '0;
    push_percent = 50;
    phase_left   = 1;

    // Directed table. Hand-checked rows cover the refusals, the first push
    // into an empty deque and the pop that empties it; the rest go through
    // the local deque. Pushing at the front from slot 0 wraps the front
    // pointer to the top slot, and the pops then walk back across the wrap.
    add_row(CMD_POP_FRONT,  32'h0000_0000, 1, 32'h0000_0000, ST_EMPTY, 4'd0);
    add_row(CMD_POP_REAR,   32'hFFFF_FFFF, 1, 32'h0000_0000, ST_EMPTY, 4'd0);
    add_row(CMD_PUSH_FRONT, 32'h8000_0000, 1, 32'h0000_0000, ST_DONE,  4'd1);
    add_row(CMD_POP_REAR,   32'h0000_0000, 1, 32'h8000_0000, ST_DONE,  4'd0);
    add_row(CMD_PUSH_REAR,  32'h7FFF_FFFF, 1, 32'h0000_0000, ST_DONE,  4'd1);
    add_row(CMD_POP_FRONT,  32'h0000_0000, 1, 32'h7FFF_FFFF, ST_DONE,  4'd0);
    add_row(CMD_PUSH_REAR,  32'hFFFF_FFFF, 1, 32'h0000_0000, ST_DONE,  4'd1);
    add_row(CMD_PUSH_FRONT, 32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_PUSH_FRONT, 32'hA5A5_5A5A, 0, '0, ST_DONE, '0);
    add_row(CMD_PUSH_REAR,  32'h5A5A_A5A5, 0, '0, ST_DONE, '0);
    add_row(CMD_PUSH_FRONT, 32'h0000_0001, 0, '0, ST_DONE, '0);
    add_row(CMD_PUSH_REAR,  32'h8000_0001, 0, '0, ST_DONE, '0);
    add_row(CMD_PUSH_FRONT, 32'hFFFF_FFFE, 0, '0, ST_DONE, '0);
    add_row(CMD_PUSH_REAR,  32'h7FFF_FFFE, 0, '0, ST_DONE, '0);
    add_row(CMD_PUSH_REAR,  32'h1234_5678, 1, 32'h0000_0000, ST_FULL,  4'd8);
    add_row(CMD_PUSH_FRONT, 32'h8000_0000, 1, 32'h0000_0000, ST_FULL,  4'd8);
    add_row(CMD_POP_FRONT,  32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_REAR,   32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_FRONT,  32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_FRONT,  32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_REAR,   32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_FRONT,  32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_REAR,   32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_REAR,   32'h0000_0000, 0, '0, ST_DONE, '0);
    add_row(CMD_POP_FRONT,  32'h0000_0000, 1, 32'h0000_0000, ST_EMPTY, 4'd0);

    // Synchronous reset, held low from the start and released on a clock edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].value, 1'b0,
                   directed_rows[i].hand_checked, directed_rows[i].want);

    // Random part. The push share changes in phases so that the deque
    // fills up and drains again many times; a few times the sender holds
    // off until the core has nothing left in flight.
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (--phase_left == 0) begin
        case ($urandom_range(2, 0))
          0:       push_percent = 20;
          1:       push_percent = 80;
          default: push_percent = 50;
        endcase
        phase_left = $urandom_range(40, 4);
      end
      if ($urandom_range(59, 0) == 0) quiet_stretch = !quiet_stretch;
      if ($urandom_range(99, 0) < push_percent)
        cmd = $urandom_range(1, 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(1, 0) ? CMD_POP_REAR : CMD_POP_FRONT;
      case ($urandom_range(15, 0))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'hFFFF_FFFF;
        3:       value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      send_command(cmd, value, (n % 300) == 0, 1'b0, no_want);
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A few more cycles to catch any stray beat after the last result.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with every wait at its
  // maximum on both sides.
  initial begin
    #7_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/cdq_pkg.sv
design/cdq_ram.sv
design/cdq_ctrl.sv
design/cdq_dp.sv
design/circular_deque_core.sv
bench/tb_circular_deque_core.sv
